// ===== src/qfm_pkg.sv =====
// Shared types and constants for the Q16.16 math unit.
// No dependencies.
package qfm_pkg;

   typedef enum logic [1:0] {
      FUNC_MUL   = 2'd0,
      FUNC_DIV   = 2'd1,
      FUNC_SQRT  = 2'd2,
      FUNC_ATAN2 = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MUL,
      ST_DIV,
      ST_SQRT,
      ST_AT_DIV,
      ST_AT_MUL1,
      ST_AT_MUL2,
      ST_AT_FOLD,
      ST_DONE
   } state_type;

   localparam int QUEUE_DEPTH = 2;
   localparam logic [31:0] MOST_NEG = 32'h8000_0000;
   localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] AT_ORIGIN = 32'h0000_C000;
   localparam logic [31:0] AT_C2000 = 32'h0000_2000;
   localparam logic [31:0] AT_C0B20 = 32'h0000_0B20;
   localparam logic [31:0] AT_ONE = 32'h0001_0000;
   localparam logic [31:0] AT_QUARTER = 32'h0000_4000;
   localparam logic [31:0] AT_HALF = 32'h0000_8000;

   function automatic logic [31:0] q_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] p;
      p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      return p[47:16];
   endfunction

endpackage

// ===== src/qfm_front.sv =====
// Front end: accepts requests into a two-entry queue.
// Depends on qfm_pkg.
module qfm_front import qfm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   item_type   mem_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

// ===== src/qfm_back.sv =====
// Back end: sequencer with a shared bit-serial divide/root unit.
// Depends on qfm_pkg.
module qfm_back import qfm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_result
);
   state_type   st_ff, st_in;
   item_type    it_ff;
   logic [47:0] num_ff, num_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] root_ff, root_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        swap_ff, swap_in, mir_ff, mir_in, ngt_ff, ngt_in;
   logic [31:0] r_ff, r_in, t_ff, t_in, res_ff, res_in;
   logic [31:0] ma, mb, ax, ay, my, tf;
   logic [31:0] at_n, at_d;
   logic        at_sw;
   logic [48:0] trial;
   logic [47:0] sbit;
   logic [48:0] strial;
   logic        accept;

   assign in_ready   = (st_ff == ST_IDLE);
   assign out_valid  = (st_ff == ST_DONE);
   assign out_result = res_ff;
   assign accept     = in_valid & in_ready;

   always_comb begin
      ma = it_ff.operand_a[31] ? (32'd0 - it_ff.operand_a) : it_ff.operand_a;
      mb = it_ff.operand_b[31] ? (32'd0 - it_ff.operand_b) : it_ff.operand_b;
      my = 32'd0 - it_ff.operand_b;
      ax = it_ff.operand_a[31] ? (32'd0 - it_ff.operand_a) : it_ff.operand_a;
      ay = my[31] ? (32'd0 - my) : my;
      at_sw = $signed(ay) > $signed(ax);
      at_n  = at_sw ? ax : ay;
      at_d  = at_sw ? ay : ax;
      trial  = {rem_ff, num_ff[47]} - {17'd0, den_ff};
      sbit   = 48'd1 << {cnt_ff, 1'b0};
      strial = {1'b0, rem_ff} - ({1'b0, root_ff} + {1'b0, sbit});
      tf = t_ff;
      if (swap_ff) tf = AT_QUARTER - tf;
      if (mir_ff) tf = AT_HALF - tf;
      if (ngt_ff) tf = 32'd0 - tf;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (accept) st_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (it_ff.func)
               FUNC_MUL: st_in = ST_MUL;
               FUNC_DIV: st_in = (it_ff.operand_b == 32'd0) ? ST_DONE : ST_DIV;
               FUNC_SQRT: st_in = (it_ff.operand_a == 32'd0 || it_ff.operand_a[31])
                                  ? ST_DONE : ST_SQRT;
               default: begin
                  if (it_ff.operand_a == 32'd0 && it_ff.operand_b == 32'd0)
                     st_in = ST_DONE;
                  else if (at_d == 32'd0)
                     st_in = ST_AT_MUL1;
                  else
                     st_in = ST_AT_DIV;
               end
            endcase
         end
         ST_MUL: st_in = ST_DONE;
         ST_DIV: if (cnt_ff == 6'd0) st_in = ST_DONE;
         ST_SQRT: if (cnt_ff == 6'd0) st_in = ST_DONE;
         ST_AT_DIV: if (cnt_ff == 6'd0) st_in = ST_AT_MUL1;
         ST_AT_MUL1: st_in = ST_AT_MUL2;
         ST_AT_MUL2: st_in = ST_AT_FOLD;
         ST_AT_FOLD: st_in = ST_DONE;
         ST_DONE: if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; root_in = root_ff; den_in = den_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; swap_in = swap_ff; mir_in = mir_ff;
      ngt_in = ngt_ff; r_in = r_ff; t_in = t_ff; res_in = res_ff;
      case (st_ff)
         ST_DISPATCH: begin
            rem_in  = 48'd0;
            root_in = 48'd0;
            cnt_in  = 6'd47;
            case (it_ff.func)
               FUNC_DIV: begin
                  num_in = {ma, 16'd0};
                  den_in = mb;
                  neg_in = it_ff.operand_a[31] ^ it_ff.operand_b[31];
                  res_in = it_ff.operand_a[31] ? MOST_NEG : MOST_POS;
               end
               FUNC_SQRT: begin
                  rem_in = {it_ff.operand_a, 16'd0};
                  cnt_in = 6'd23;
                  res_in = 32'd0;
               end
               FUNC_ATAN2: begin
                  mir_in = it_ff.operand_a[31];
                  ngt_in = my[31];
                  swap_in = at_sw;
                  num_in = {at_n, 16'd0};
                  den_in = at_d;
                  neg_in = at_n[31] ^ at_d[31];
                  r_in   = at_n[31] ? MOST_NEG : MOST_POS;
                  res_in = AT_ORIGIN;
               end
               default: ;
            endcase
         end
         ST_MUL: res_in = q_mul(it_ff.operand_a, it_ff.operand_b);
         ST_DIV, ST_AT_DIV: begin
            if (!trial[48]) rem_in = trial[47:0];
            else rem_in = {rem_ff[46:0], num_ff[47]};
            num_in = {num_ff[46:0], ~trial[48]};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               r_in   = neg_ff ? (32'd0 - num_in[31:0]) : num_in[31:0];
               res_in = r_in;
            end
         end
         ST_SQRT: begin
            if (!strial[48]) begin
               rem_in  = strial[47:0];
               root_in = (root_ff >> 1) + sbit;
            end else begin
               root_in = root_ff >> 1;
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) res_in = root_in[31:0];
         end
         ST_AT_MUL1: t_in = q_mul(AT_C0B20, AT_ONE - r_ff);
         ST_AT_MUL2: t_in = q_mul(r_ff, AT_C2000 + t_ff);
         ST_AT_FOLD: res_in = {16'd0, tf[15:0]};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
      if (accept) it_ff <= in_item;
      num_ff <= num_in; rem_ff <= rem_in; root_ff <= root_in; den_ff <= den_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; swap_ff <= swap_in; mir_ff <= mir_in;
      ngt_ff <= ngt_in; r_ff <= r_in; t_ff <= t_in; res_ff <= res_in;
   end
endmodule

// ===== src/q16_fixed_math_unit.sv =====
// Top level of the Q16.16 math unit: request queue plus sequencer.
// Divide, square root and atan2 are bit-serial; divide by zero, a non-positive root or atan2 at
// the origin skip the serial steps, and a zero atan2 divisor skips the divide.
// The sequencer takes a new request only after the last response is accepted; the queue holds up to two more.
// Reset: synchronous active high; clears the queue and the sequencer.
// Depends on qfm_pkg, qfm_front, qfm_back.
module q16_fixed_math_unit import qfm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // func[1:0]
   input  logic [63:0] req_tdata,  // operand_a[31:0], operand_b[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // result[31:0]
);
   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item.func      = func_type'(req_tuser);
   assign in_item.operand_a = req_tdata[31:0];
   assign in_item.operand_b = req_tdata[63:32];

   qfm_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   qfm_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(rsp_tdata)
   );
endmodule

// ===== src/qfm_checker.sv =====
// Port checker for the Q16.16 math unit, bound to the top level.
// Depends on q16_fixed_math_unit.
module qfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response right after reset");
   a_ready_after_reset: assert property (@(posedge clock)
      reset ##1 !reset |-> req_tready)
      else $error("queue not ready after reset");
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("two responses in consecutive cycles");
endmodule

bind q16_fixed_math_unit qfm_checker u_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
